[hw/rtl/kmd_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kmd_pkg
// shared sizes, types and helpers for the key matrix debounce block
// ----------------------------------------------------------------------------
package kmd_pkg;

    localparam int ROW_COUNT    = 10;
    localparam int COLUMN_COUNT = 8;
    localparam int ROW_W        = (ROW_COUNT > 1) ? $clog2(ROW_COUNT) : 1;
    localparam int COL_W        = (COLUMN_COUNT > 1) ? $clog2(COLUMN_COUNT) : 1;

    localparam int ROW_INDEX_W  = 4;
    localparam int ROW_BITS_W   = 8;
    localparam int QUERY_COL_W  = 3;
    localparam int SETTLE_W     = 8;
    localparam int PCOUNT_W     = 7;

    localparam logic [SETTLE_W-1:0] RESET_SETTLE = SETTLE_W'(5);

    typedef logic [COLUMN_COUNT-1:0] t_cols;
    typedef logic [ROW_W-1:0]        t_row_sel;
    typedef logic [PCOUNT_W-1:0]     t_pcount;

    typedef struct packed {
        logic [ROW_INDEX_W-1:0] row_index;
        logic [ROW_BITS_W-1:0]  row_bits;
        logic [QUERY_COL_W-1:0] query_column;
    } t_item;

    typedef struct packed {
        logic                  settled;
        logic [ROW_BITS_W-1:0] stable_row;
        logic                  key_pressed;
        t_pcount               pressed_count;
    } t_result;

    function automatic t_pcount f_popcount(t_cols v);
        t_pcount n;
        n = '0;
        for (int i = 0; i < COLUMN_COUNT; i++) begin
            n = n + t_pcount'(v[i]);
        end
        return n;
    endfunction

endpackage

[hw/rtl/kmd_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kmd_if
// valid/ready channel interfaces for row samples, results and configuration
// ----------------------------------------------------------------------------
interface kmd_row_if import kmd_pkg::*; ();
    logic                   valid;
    logic                   ready;
    logic [ROW_INDEX_W-1:0] row_index;
    logic [ROW_BITS_W-1:0]  row_bits;
    logic [QUERY_COL_W-1:0] query_column;

    modport source (output valid, output row_index, output row_bits,
                    output query_column, input ready);
    modport sink   (input valid, input row_index, input row_bits,
                    input query_column, output ready);
endinterface

interface kmd_res_if import kmd_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic                  settled;
    logic [ROW_BITS_W-1:0] stable_row;
    logic                  key_pressed;
    logic [PCOUNT_W-1:0]   pressed_count;

    modport source (output valid, output settled, output stable_row,
                    output key_pressed, output pressed_count, input ready);
    modport sink   (input valid, input settled, input stable_row,
                    input key_pressed, input pressed_count, output ready);
endinterface

interface kmd_cfg_if import kmd_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [SETTLE_W-1:0] data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

[hw/rtl/key_matrix_debounce.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// key_matrix_debounce
// keyboard matrix debounce with one global settle counter over full scans
// ----------------------------------------------------------------------------
//  channel  dir  payload                                             handshake
//  i_row    in   row_index, row_bits, query_column                   valid/ready
//  o_res    out  settled, stable_row, key_pressed, pressed_count     valid/ready
//  i_cfg    in   data (settle_scans)                                 valid/ready
//
//  one row sample per cycle sustained while the result register is not stalled; a
//  result passes the input register, then the state update into the result
//  register, before it is valid
//  the pressed-key total is kept as a running count, so no wide adder tree
//  reset clears both matrices and loads the settle count and counter with 5
//  a stalled result register holds the input register, which then drops ready
//  configuration is always ready; the block does not enforce it, the user must write it only while the block is idle
// ----------------------------------------------------------------------------
module key_matrix_debounce import kmd_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    kmd_row_if.sink   i_row,
    kmd_res_if.source o_res,
    kmd_cfg_if.sink   i_cfg
);

    t_item   in_item;
    t_item   held_item;
    logic    held_valid;
    logic    out_free;
    logic    step;
    t_result step_result;
    t_result out_result;
    logic    out_valid;

    assign in_item.row_index    = i_row.row_index;
    assign in_item.row_bits     = i_row.row_bits;
    assign in_item.query_column = i_row.query_column;

    assign step        = held_valid && out_free;
    assign i_cfg.ready = 1'b1;

    kmd_in_stage u_in (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_row.valid),
        .i_item  (in_item),
        .o_ready (i_row.ready),
        .i_take  (step),
        .o_valid (held_valid),
        .o_item  (held_item)
    );

    kmd_core u_core (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg.valid),
        .i_cfg_data (i_cfg.data),
        .i_step     (step),
        .i_item     (held_item),
        .o_result   (step_result)
    );

    kmd_out_stage u_out (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (step),
        .i_result (step_result),
        .i_ready  (o_res.ready),
        .o_free   (out_free),
        .o_valid  (out_valid),
        .o_result (out_result)
    );

    assign o_res.valid         = out_valid;
    assign o_res.settled       = out_result.settled;
    assign o_res.stable_row    = out_result.stable_row;
    assign o_res.key_pressed   = out_result.key_pressed;
    assign o_res.pressed_count = out_result.pressed_count;

endmodule

[hw/rtl/kmd_in_stage.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kmd_in_stage
// input register for one row sample, refilled in the cycle it drains
// ----------------------------------------------------------------------------
module kmd_in_stage import kmd_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_valid,
    input  t_item i_item,
    output logic  o_ready,
    input  logic  i_take,
    output logic  o_valid,
    output t_item o_item
);

    logic  r_valid;
    t_item r_item;

    assign o_ready = !r_valid || i_take;
    assign o_valid = r_valid;
    assign o_item  = r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_item <= i_item;
        end
    end

endmodule

[hw/rtl/kmd_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kmd_core
// raw and stable matrices, global settle counter and pressed-key count
// ----------------------------------------------------------------------------
module kmd_core import kmd_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  logic [SETTLE_W-1:0] i_cfg_data,
    input  logic                i_step,
    input  t_item               i_item,
    output t_result             o_result
);

    t_cols               r_raw [ROW_COUNT];
    t_cols               r_stable [ROW_COUNT];
    logic [SETTLE_W-1:0] r_counter;
    logic [SETTLE_W-1:0] r_scans;
    t_pcount             r_raw_count;
    t_pcount             r_stable_count;

    t_cols               n_raw [ROW_COUNT];
    t_cols               n_stable [ROW_COUNT];
    logic [SETTLE_W-1:0] n_counter;
    t_pcount             n_raw_count;
    t_pcount             n_stable_count;

    logic [SETTLE_W-1:0] reload;
    logic [SETTLE_W-1:0] cnt_loaded;
    logic                row_ok;
    logic                last_row;
    logic                changed;
    logic                copy_all;
    t_row_sel            sel;
    t_cols               bits;
    t_cols               old_row;
    t_cols               srow;
    logic                key;

    always_comb begin
        reload   = (r_scans == '0) ? SETTLE_W'(1) : r_scans;
        row_ok   = 32'(i_item.row_index) < ROW_COUNT;
        last_row = 32'(i_item.row_index) == ROW_COUNT - 1;
        sel      = t_row_sel'(i_item.row_index);
        bits     = t_cols'(i_item.row_bits);
        old_row  = r_raw[sel];
        changed  = row_ok && (old_row != bits);

        cnt_loaded  = changed ? reload : r_counter;
        n_raw_count = r_raw_count;
        if (changed) begin
            n_raw_count = r_raw_count - f_popcount(old_row) + f_popcount(bits);
        end

        n_counter = cnt_loaded;
        copy_all  = 1'b0;
        if (last_row && cnt_loaded != '0) begin
            n_counter = cnt_loaded - SETTLE_W'(1);
            copy_all  = (cnt_loaded == SETTLE_W'(1));
        end

        for (int i = 0; i < ROW_COUNT; i++) begin
            n_raw[i] = (changed && sel == t_row_sel'(i)) ? bits : r_raw[i];
        end
        for (int i = 0; i < ROW_COUNT; i++) begin
            n_stable[i] = copy_all ? n_raw[i] : r_stable[i];
        end
        n_stable_count = copy_all ? n_raw_count : r_stable_count;

        srow = row_ok ? n_stable[sel] : '0;
        key  = 1'b0;
        if (32'(i_item.query_column) < COLUMN_COUNT) begin
            key = srow[COL_W'(i_item.query_column)];
        end

        o_result.settled       = (n_counter == '0);
        o_result.stable_row    = ROW_BITS_W'(srow);
        o_result.key_pressed   = key;
        o_result.pressed_count = n_stable_count;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scans <= RESET_SETTLE;
        end else if (i_cfg_we) begin
            r_scans <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < ROW_COUNT; i++) begin
                r_raw[i]    <= '0;
                r_stable[i] <= '0;
            end
            r_counter      <= RESET_SETTLE;
            r_raw_count    <= '0;
            r_stable_count <= '0;
        end else if (i_step) begin
            for (int i = 0; i < ROW_COUNT; i++) begin
                r_raw[i]    <= n_raw[i];
                r_stable[i] <= n_stable[i];
            end
            r_counter      <= n_counter;
            r_raw_count    <= n_raw_count;
            r_stable_count <= n_stable_count;
        end
    end

endmodule

[hw/rtl/kmd_out_stage.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kmd_out_stage
// result register, loaded on a step while it is empty or being drained
// ----------------------------------------------------------------------------
module kmd_out_stage import kmd_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_load,
    input  t_result i_result,
    input  logic    i_ready,
    output logic    o_free,
    output logic    o_valid,
    output t_result o_result
);

    logic    r_valid;
    t_result r_result;

    assign o_free   = !r_valid || i_ready;
    assign o_valid  = r_valid;
    assign o_result = r_result;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_free) begin
            r_valid <= i_load;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_free && i_load) begin
            r_result <= i_result;
        end
    end

endmodule
